// ===== sv/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rdq_pkg: shared types and constants for the restricted deque
// Operation codes, response status codes and the token that walks the cells.
// ----------------------------------------------------------------------------
package rdq_pkg;

   localparam int RDQ_DEPTH = 8;
   localparam int DATA_W    = 32;

   typedef enum logic [2:0] {
      OP_PUSH_REAR  = 3'd0,
      OP_POP_FRONT  = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_SEARCH     = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_BLOCKED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TOK_NONE   = 2'd0,
      TOK_WRITE  = 2'd1,
      TOK_READ   = 2'd2,
      TOK_SEARCH = 2'd3
   } tok_kind_type;

   // travels one cell per cycle unless the row stalls; value is the write
   // data, the read result or the search key depending on kind
   typedef struct packed {
      logic                valid;
      tok_kind_type        kind;
      logic [DATA_W-1:0]   value;
      logic                hit;
   } token_type;

endpackage

// ===== sv/rdq_ifs.sv =====
// ----------------------------------------------------------------------------
// rdq_ifs: request and response channels of the restricted deque
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rdq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface rdq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] data;
   logic               found;
   logic               is_full;
   logic               is_empty;

   modport source (output valid, output status, output data, output found,
                   output is_full, output is_empty, input ready);
   modport sink   (input valid, input status, input data, input found,
                   input is_full, input is_empty, output ready);
endinterface

// ===== sv/rdq_cell.sv =====
// ----------------------------------------------------------------------------
// rdq_cell: one slot of the deque
// Holds one entry and passes the token on to its neighbor, writing, reading
// or comparing against the entry on the way.
// ----------------------------------------------------------------------------
module rdq_cell
   import rdq_pkg::*;
#(
   parameter int DEPTH    = RDQ_DEPTH,
   parameter int CELL_IDX = 0,
   localparam int IW      = $clog2(DEPTH),
   localparam int CW      = $clog2(DEPTH + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  token_type       tok_i,
   input  logic [IW-1:0]   tgt_i,
   input  logic [CW-1:0]   lo_i,
   input  logic [CW-1:0]   hi_i,
   output token_type       tok_o,
   output logic [IW-1:0]   tgt_o,
   output logic [CW-1:0]   lo_o,
   output logic [CW-1:0]   hi_o
);

   localparam logic [IW-1:0] MY_IDX  = IW'(CELL_IDX);
   localparam logic [CW-1:0] MY_SLOT = CW'(CELL_IDX);

   logic [DATA_W-1:0] entry_ff;
   token_type         tok_ff, tok_in;
   logic [IW-1:0]     tgt_ff;
   logic [CW-1:0]     lo_ff, hi_ff;
   logic              is_tgt, is_live;

   assign is_tgt  = tok_i.valid && (tgt_i == MY_IDX);
   assign is_live = (MY_SLOT >= lo_i) && (MY_SLOT < hi_i);

   always_comb begin
      tok_in = tok_i;
      if (is_tgt && tok_i.kind == TOK_READ) begin
         tok_in.value = entry_ff;
      end
      if (tok_i.valid && tok_i.kind == TOK_SEARCH && is_live
          && entry_ff == tok_i.value) begin
         tok_in.hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_tgt && tok_i.kind == TOK_WRITE) begin
         entry_ff <= tok_i.value;
      end
      if (advance) begin
         tok_ff.kind  <= tok_in.kind;
         tok_ff.value <= tok_in.value;
         tok_ff.hit   <= tok_in.hit;
         tgt_ff       <= tgt_i;
         lo_ff        <= lo_i;
         hi_ff        <= hi_i;
      end
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff.valid <= tok_in.valid;
      end
   end

   assign tok_o = tok_ff;
   assign tgt_o = tgt_ff;
   assign lo_o  = lo_ff;
   assign hi_o  = hi_ff;

endmodule

// ===== sv/restricted_deque_with_search_top.sv =====
// ----------------------------------------------------------------------------
// restricted_deque_with_search_top: non-wrapping deque with key search
// Pointers live here; entries live in a row of cells that a token walks.
// ----------------------------------------------------------------------------
// Path: the token crosses the cell registers one by one, then the response
//   register loads; the token stalls at the end of the row while a response waits unread.
// Requests: a new beat is taken only once the response has loaded; the row carries one token.
// Reset: pointers to empty, restrict mode to 0, no beat pending; entry
//   contents are left as they are.
// ----------------------------------------------------------------------------
module restricted_deque_with_search_top
   import rdq_pkg::*;
#(
   parameter int DEPTH = RDQ_DEPTH,
   localparam int IW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   rdq_req_if.sink     req_bus,
   rdq_rsp_if.source   rsp_bus
);

   localparam logic [CW-1:0] FULL_POS = CW'(DEPTH);

   // front_ff is the slot of the front entry; rear_ff is one past the slot of the rear entry
   logic [CW-1:0] front_ff, front_in, rear_ff, rear_in;
   logic          mode_ff, busy_ff, busy_in;
   logic          accept, advance, load_rsp;

   status_type    st_in, pend_status_ff;
   logic          pend_full_ff, pend_empty_ff;
   tok_kind_type  kind_in;
   logic [CW-1:0] tgt_pos;

   token_type     tok  [0:DEPTH];
   logic [IW-1:0] tgt  [0:DEPTH];
   logic [CW-1:0] lo   [0:DEPTH];
   logic [CW-1:0] hi   [0:DEPTH];
   logic [DEPTH:0] chain_valid;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_found_ff, rsp_full_ff, rsp_empty_ff;

   assign req_bus.ready = !busy_ff;
   assign accept        = req_bus.valid && !busy_ff;
   assign advance       = !(tok[DEPTH].valid && rsp_valid_ff && !rsp_bus.ready);
   assign load_rsp      = tok[DEPTH].valid && advance;

   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      st_in    = ST_OK;
      kind_in  = TOK_NONE;
      tgt_pos  = rear_ff;
      unique case (opcode_type'(req_bus.opcode))
         OP_PUSH_REAR: begin
            if (rear_ff == FULL_POS) begin
               st_in = ST_FULL;
            end else begin
               kind_in = TOK_WRITE;
               tgt_pos = rear_ff;
               rear_in = rear_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (front_ff == rear_ff) begin
               st_in = ST_EMPTY;
            end else begin
               kind_in  = TOK_READ;
               tgt_pos  = front_ff;
               front_in = front_ff + 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (mode_ff) begin
               st_in = ST_BLOCKED;
            end else if (front_ff == '0) begin
               st_in = ST_FULL;
            end else begin
               kind_in  = TOK_WRITE;
               tgt_pos  = front_ff - 1'b1;
               front_in = front_ff - 1'b1;
            end
         end
         OP_POP_REAR: begin
            if (!mode_ff) begin
               st_in = ST_BLOCKED;
            end else if (front_ff == rear_ff) begin
               st_in = ST_EMPTY;
            end else begin
               kind_in = TOK_READ;
               tgt_pos = rear_ff - 1'b1;
               rear_in = rear_ff - 1'b1;
            end
         end
         OP_SEARCH: begin
            kind_in = TOK_SEARCH;
         end
         default: begin
            st_in = ST_BLOCKED;
         end
      endcase
   end

   // token enters cell 0 in the cycle of the request beat
   assign tok[0].valid = accept;
   assign tok[0].kind  = kind_in;
   assign tok[0].value = $unsigned(req_bus.value);
   assign tok[0].hit   = 1'b0;
   assign tgt[0]       = tgt_pos[IW-1:0];
   assign lo[0]        = front_ff;
   assign hi[0]        = rear_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      rdq_cell #(
         .DEPTH    (DEPTH),
         .CELL_IDX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_i   (tok[g]),
         .tgt_i   (tgt[g]),
         .lo_i    (lo[g]),
         .hi_i    (hi[g]),
         .tok_o   (tok[g+1]),
         .tgt_o   (tgt[g+1]),
         .lo_o    (lo[g+1]),
         .hi_o    (hi[g+1])
      );
   end

   for (genvar g = 0; g <= DEPTH; g++) begin : g_vld
      assign chain_valid[g] = tok[g].valid;
   end

   assign busy_in      = accept ? 1'b1 : (load_rsp ? 1'b0 : busy_ff);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         mode_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (accept) begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= st_in;
         pend_full_ff   <= (rear_in == FULL_POS);
         pend_empty_ff  <= (front_in == rear_in);
      end
      if (load_rsp) begin
         rsp_status_ff <= pend_status_ff;
         rsp_data_ff   <= (tok[DEPTH].kind == TOK_READ) ? tok[DEPTH].value : '0;
         rsp_found_ff  <= (tok[DEPTH].kind == TOK_SEARCH) && tok[DEPTH].hit;
         rsp_full_ff   <= pend_full_ff;
         rsp_empty_ff  <= pend_empty_ff;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.data     = $signed(rsp_data_ff);
   assign rsp_bus.found    = rsp_found_ff;
   assign rsp_bus.is_full  = rsp_full_ff;
   assign rsp_bus.is_empty = rsp_empty_ff;

   // one token in the cell row at most
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one token in the cell row");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      tok[DEPTH].valid |-> busy_ff)
      else $error("token leaves the row while no request is pending");

   a_ptr_order: assert property (@(posedge clock) disable iff (reset)
      (front_ff <= rear_ff) && (rear_ff <= FULL_POS))
      else $error("front/rear pointers out of order");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("request accepted while previous beat still in flight");

endmodule
